FILE: sv/kfls_pkg.sv
// Shared types and constants of the keyframe linear sampler.
// Used by every module; depends on nothing.
package kfls_pkg;

  localparam int MAX_KEYS = 64;
  localparam int IDX_W = $clog2(MAX_KEYS);
  localparam int CNT_W = $clog2(MAX_KEYS + 1);
  localparam int ITER_W = 5;
  localparam int FRAC_W = 31;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;

  localparam logic [1:0] ST_SAMPLED = 2'd0;
  localparam logic [1:0] ST_ACCEPTED = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  typedef struct packed {
    logic signed [31:0] t;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } key_t;

  typedef struct packed {
    logic start;
    logic step;
  } lane_ctl_t;

endpackage

FILE: sv/kfls_if.sv
// Request and result channel interfaces of the keyframe linear sampler.
// Depends on nothing.
interface kfls_req_if;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic signed [31:0] key_time;
  logic signed [31:0] key_x;
  logic signed [31:0] key_y;
  logic signed [31:0] key_z;
  logic signed [31:0] query_time;
  modport source(output valid, kind, key_time, key_x, key_y, key_z, query_time, input ready);
  modport sink(input valid, kind, key_time, key_x, key_y, key_z, query_time, output ready);
endinterface

interface kfls_rsp_if;
  logic valid;
  logic ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [1:0] status;
  modport source(output valid, out_x, out_y, out_z, status, input ready);
  modport sink(input valid, out_x, out_y, out_z, status, output ready);
endinterface

FILE: sv/kfls_cell.sv
// One keyframe cell of the key ring.
// Depends on kfls_pkg.
module kfls_cell (
  input  logic          clk,
  input  logic          shift,
  input  logic          load,
  input  kfls_pkg::key_t nb_key,
  input  kfls_pkg::key_t wr_key,
  output kfls_pkg::key_t key
);

  always_ff @(posedge clk) begin
    if (load) begin
      key <= wr_key;
    end else if (shift) begin
      key <= nb_key;
    end
  end

endmodule

FILE: sv/kfls_chain.sv
// Ring of keyframe cells; each shift moves every key one cell toward the head.
// Depends on kfls_pkg and kfls_cell.
module kfls_chain (
  input  logic                        clk,
  input  logic                        shift,
  input  logic                        wr_en,
  input  logic [kfls_pkg::IDX_W-1:0]  wr_idx,
  input  kfls_pkg::key_t              wr_key,
  output kfls_pkg::key_t              head
);

  kfls_pkg::key_t keys [kfls_pkg::MAX_KEYS];

  for (genvar i = 0; i < kfls_pkg::MAX_KEYS; i++) begin : g_cell
    kfls_cell u_cell (
      .clk    (clk),
      .shift  (shift),
      .load   (wr_en && (wr_idx == kfls_pkg::IDX_W'(i))),
      .nb_key (keys[(i + 1) % kfls_pkg::MAX_KEYS]),
      .wr_key (wr_key),
      .key    (keys[i])
    );
  end

  assign head = keys[0];

endmodule

FILE: sv/kfls_lane.sv
// One value lane of the blend: bit-serial multiply of the difference by the
// fraction, then rounding, add and saturation. Depends on kfls_pkg.
module kfls_lane (
  input  logic                         clk,
  input  kfls_pkg::lane_ctl_t          ctl,
  input  logic [kfls_pkg::FRAC_W-1:0]  frac,
  input  logic                         num_neg,
  input  logic signed [31:0]           a,
  input  logic signed [31:0]           b,
  output logic signed [31:0]           result
);

  logic [62:0] acc;
  logic [32:0] dmag;
  logic [kfls_pkg::FRAC_W-1:0] fr;
  logic neg;
  logic [32:0] diff;
  logic [63:0] rnd;
  logic [35:0] qx;
  logic signed [35:0] sum;

  assign diff = {b[31], b} - {a[31], a};

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dmag <= diff[32] ? (33'd0 - diff) : diff;
      neg <= num_neg ^ diff[32];
      acc <= '0;
      fr <= frac;
    end else if (ctl.step) begin
      acc <= {acc[61:0], 1'b0} + (fr[kfls_pkg::FRAC_W-1] ? {30'd0, dmag} : 63'd0);
      fr <= {fr[kfls_pkg::FRAC_W-2:0], 1'b0};
    end
  end

  always_comb begin
    rnd = {1'b0, acc} + 64'd536870912;
    qx = {2'b00, rnd[63:30]};
    sum = signed'({{4{a[31]}}, a}) + signed'(neg ? (36'd0 - qx) : qx);
    if (sum > 36'sd2147483647) begin
      result = 32'sh7fffffff;
    end else if (sum < -36'sd2147483648) begin
      result = 32'sh80000000;
    end else begin
      result = sum[31:0];
    end
  end

endmodule

FILE: sv/keyframe_linear_sampler.sv
// Keyframe linear sampler: a clear or append result is valid in the cycle after acceptance.
// A sample result is worked out in order by a bit-serial modulo of the query time (only
// with loop_enable set), a walk over the whole key ring, a bit-serial divide for the
// fraction, a bit-serial multiply in the value lanes and the control states between them.
// One request is worked on at a time; the next is taken once the result register is free.
// Reset is synchronous and clears the key count, loop_enable and the handshakes.
module keyframe_linear_sampler (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  kfls_req_if.sink      in_ch,
  kfls_rsp_if.source    out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_SEARCH, S_PREP, S_DIV, S_LOAD, S_MUL, S_FIN, S_DONE
  } state_t;

  state_t state;
  logic loop_en;
  logic [kfls_pkg::CNT_W-1:0] count;
  kfls_pkg::key_t last_key, prev, ka, kb, head, wr_key;
  logic [kfls_pkg::IDX_W-1:0] step;
  logic [kfls_pkg::ITER_W-1:0] iter;
  logic signed [31:0] tt;
  logic t_neg;
  logic [31:0] mod_rem, dvd;
  logic found;
  logic [31:0] span_u;
  logic [33:0] div_rem;
  logic [kfls_pkg::FRAC_W-1:0] frac;
  logic num_neg;
  logic signed [31:0] res_x, res_y, res_z;
  logic [1:0] res_status;
  logic out_free, take, shift, wr_en, res_load;
  kfls_pkg::lane_ctl_t ctl;
  logic signed [31:0] lx, ly, lz;

  logic [32:0] mod_sh, mod_new;
  logic [32:0] span33;
  logic signed [33:0] num34, spanx, numc;
  logic [33:0] mag;
  logic div_ge;
  logic [33:0] div_sub;
  logic hit;
  logic [31:0] qabs;

  assign out_free = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && out_free && !rst;
  assign take = in_ch.valid && in_ch.ready;
  assign res_load = (take && (in_ch.kind inside {kfls_pkg::KIND_CLEAR, kfls_pkg::KIND_APPEND})) ||
                    ((state == S_DONE) && out_free);
  assign shift = (state == S_SEARCH);
  assign wr_en = take && (in_ch.kind == kfls_pkg::KIND_APPEND) &&
                 (count < kfls_pkg::CNT_W'(kfls_pkg::MAX_KEYS));
  assign wr_key = '{t: in_ch.key_time, x: in_ch.key_x, y: in_ch.key_y, z: in_ch.key_z};
  assign ctl = '{start: (state == S_LOAD), step: (state == S_MUL)};

  kfls_chain u_chain (
    .clk    (clk),
    .shift  (shift),
    .wr_en  (wr_en),
    .wr_idx (count[kfls_pkg::IDX_W-1:0]),
    .wr_key (wr_key),
    .head   (head)
  );

  kfls_lane u_lane_x (.clk(clk), .ctl(ctl), .frac(frac), .num_neg(num_neg),
                      .a(ka.x), .b(kb.x), .result(lx));
  kfls_lane u_lane_y (.clk(clk), .ctl(ctl), .frac(frac), .num_neg(num_neg),
                      .a(ka.y), .b(kb.y), .result(ly));
  kfls_lane u_lane_z (.clk(clk), .ctl(ctl), .frac(frac), .num_neg(num_neg),
                      .a(ka.z), .b(kb.z), .result(lz));

  always_comb begin
    qabs = in_ch.query_time[31] ? (32'd0 - in_ch.query_time) : in_ch.query_time;
    mod_sh = {mod_rem, dvd[31]};
    mod_new = (mod_sh >= {1'b0, last_key.t}) ? (mod_sh - {1'b0, last_key.t}) : mod_sh;
    hit = !found && (step != '0) &&
          (kfls_pkg::CNT_W'(step) < count) && (head.t >= tt);
    span33 = {kb.t[31], kb.t} - {ka.t[31], ka.t};
    num34 = {{2{tt[31]}}, tt} - {{2{ka.t[31]}}, ka.t};
    spanx = {span33[32], span33};
    numc = num34;
    if (num34 > spanx) begin
      numc = spanx;
    end else if (num34 < -spanx) begin
      numc = -spanx;
    end
    mag = numc[33] ? (34'd0 - numc) : numc;
    div_ge = div_rem >= {2'b00, span_u};
    div_sub = div_ge ? (div_rem - {2'b00, span_u}) : div_rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      loop_en <= 1'b0;
      count <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        loop_en <= cfg_wr_data;
      end
      if (out_ch.valid && out_ch.ready && !res_load) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            if (in_ch.kind == kfls_pkg::KIND_CLEAR) begin
              count <= '0;
              out_ch.valid <= 1'b1;
              out_ch.status <= kfls_pkg::ST_CLEARED;
              out_ch.out_x <= '0;
              out_ch.out_y <= '0;
              out_ch.out_z <= '0;
            end else if (in_ch.kind == kfls_pkg::KIND_APPEND) begin
              out_ch.valid <= 1'b1;
              out_ch.out_x <= '0;
              out_ch.out_y <= '0;
              out_ch.out_z <= '0;
              if (wr_en) begin
                count <= count + kfls_pkg::CNT_W'(1);
                last_key <= wr_key;
                out_ch.status <= kfls_pkg::ST_ACCEPTED;
              end else begin
                out_ch.status <= kfls_pkg::ST_FULL;
              end
            end else begin
              res_status <= kfls_pkg::ST_SAMPLED;
              step <= '0;
              iter <= '0;
              found <= 1'b0;
              t_neg <= in_ch.query_time[31];
              mod_rem <= '0;
              dvd <= qabs;
              if (count == '0) begin
                res_x <= '0;
                res_y <= '0;
                res_z <= '0;
                state <= S_DONE;
              end else if (count == kfls_pkg::CNT_W'(1)) begin
                res_x <= last_key.x;
                res_y <= last_key.y;
                res_z <= last_key.z;
                state <= S_DONE;
              end else if (loop_en) begin
                if (last_key.t <= 0) begin
                  tt <= '0;
                  state <= S_SEARCH;
                end else begin
                  state <= S_MOD;
                end
              end else begin
                tt <= (in_ch.query_time < last_key.t) ? in_ch.query_time : last_key.t;
                state <= S_SEARCH;
              end
            end
          end
        end
        S_MOD: begin
          mod_rem <= mod_new[31:0];
          dvd <= {dvd[30:0], 1'b0};
          iter <= iter + kfls_pkg::ITER_W'(1);
          if (iter == '1) begin
            tt <= (t_neg && mod_new != '0) ? (last_key.t - mod_new[31:0]) : mod_new[31:0];
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          prev <= head;
          if (hit) begin
            found <= 1'b1;
            ka <= prev;
            kb <= head;
          end
          step <= step + kfls_pkg::IDX_W'(1);
          if (step == kfls_pkg::IDX_W'(kfls_pkg::MAX_KEYS - 1)) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          iter <= '0;
          if (!found) begin
            res_x <= last_key.x;
            res_y <= last_key.y;
            res_z <= last_key.z;
            state <= S_DONE;
          end else if (span33[32] || span33 == '0) begin
            res_x <= ka.x;
            res_y <= ka.y;
            res_z <= ka.z;
            state <= S_DONE;
          end else begin
            span_u <= span33[31:0];
            div_rem <= mag;
            num_neg <= numc[33];
            state <= S_DIV;
          end
        end
        S_DIV: begin
          div_rem <= {div_sub[32:0], 1'b0};
          frac <= {frac[kfls_pkg::FRAC_W-2:0], div_ge};
          iter <= iter + kfls_pkg::ITER_W'(1);
          if (iter == kfls_pkg::ITER_W'(kfls_pkg::FRAC_W - 1)) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          iter <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          iter <= iter + kfls_pkg::ITER_W'(1);
          if (iter == kfls_pkg::ITER_W'(kfls_pkg::FRAC_W - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          res_x <= lx;
          res_y <= ly;
          res_z <= lz;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_ch.valid <= 1'b1;
            out_ch.out_x <= res_x;
            out_ch.out_y <= res_y;
            out_ch.out_z <= res_z;
            out_ch.status <= res_status;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/kfls_checker.sv
// Port-level checks of the keyframe linear sampler and their bind.
// Depends on kfls_pkg and the top level's ports.
module kfls_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z,
  input logic [1:0]  out_status
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_kind == kfls_pkg::KIND_CLEAR |=>
    out_valid && out_status == kfls_pkg::ST_CLEARED)
    else $error("clear request gave no cleared result");

  a_append: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_kind == kfls_pkg::KIND_APPEND |=>
    out_valid && (out_status == kfls_pkg::ST_ACCEPTED || out_status == kfls_pkg::ST_FULL))
    else $error("append request gave a wrong status");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != kfls_pkg::ST_SAMPLED |->
    out_x == '0 && out_y == '0 && out_z == '0)
    else $error("table result carries nonzero values");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind keyframe_linear_sampler kfls_checker u_kfls_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_kind    (in_ch.kind),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_x      (out_ch.out_x),
  .out_y      (out_ch.out_y),
  .out_z      (out_ch.out_z),
  .out_status (out_ch.status)
);
